/* hw/rtl/mck_pkg.sv */
// mck_pkg: shared types, constants and the character code table of the morse keyer
// depends on nothing; imported by every module of the keyer
package mck_pkg;

    // character queue geometry
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // function codes on the command channel
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DIT       = 2'd0;
    localparam logic [1:0] CFG_DAH       = 2'd1;
    localparam logic [1:0] CFG_ELEM_GAP  = 2'd2;
    localparam logic [1:0] CFG_CHAR_GAP  = 2'd3;

    // configuration reset values
    localparam logic [7:0] DIT_RESET       = 8'd4;
    localparam logic [7:0] DAH_RESET       = 8'd12;
    localparam logic [7:0] ELEM_GAP_RESET  = 8'd8;
    localparam logic [7:0] CHAR_GAP_RESET  = 8'd28;

    localparam int LETTER_COUNT = 26;
    localparam int CODE_COUNT   = 36;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
    } mck_cmd_t;

    typedef struct packed {
        logic tone_on;
        logic idle;
        logic accepted;
    } mck_status_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_PUT,
        OP_TICK,
        OP_CLEAR
    } mck_op_kind_t;

    // classified command handed from front to back
    typedef struct packed {
        mck_op_kind_t kind;
        logic [7:0]   code;
    } mck_op_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } mck_lookup_t;

    // code byte: element count in [7:5], pattern in [4:0], lsb first, 1 is a dah
    localparam logic [7:0] CODE_ROM [CODE_COUNT] = '{
        {3'd2, 5'd2},  {3'd4, 5'd1},  {3'd4, 5'd5},  {3'd3, 5'd1},  {3'd1, 5'd0},
        {3'd4, 5'd4},  {3'd3, 5'd3},  {3'd4, 5'd0},  {3'd2, 5'd0},  {3'd4, 5'd14},
        {3'd3, 5'd5},  {3'd4, 5'd2},  {3'd2, 5'd3},  {3'd2, 5'd1},  {3'd3, 5'd7},
        {3'd4, 5'd6},  {3'd4, 5'd11}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
        {3'd3, 5'd4},  {3'd4, 5'd8},  {3'd3, 5'd6},  {3'd4, 5'd9},  {3'd4, 5'd13},
        {3'd4, 5'd3},
        {3'd5, 5'd31}, {3'd5, 5'd30}, {3'd5, 5'd28}, {3'd5, 5'd24}, {3'd5, 5'd16},
        {3'd5, 5'd0},  {3'd5, 5'd1},  {3'd5, 5'd3},  {3'd5, 5'd7},  {3'd5, 5'd15}
    };

    // map an ascii letter (either case) or digit to its code byte
    function automatic mck_lookup_t code_lookup(input logic [7:0] c);
        mck_lookup_t res;
        logic [5:0]  idx;
        res.valid = 1'b1;
        idx       = '0;
        if (c inside {[8'h61:8'h7A]})
            idx = 6'(c - 8'h61);
        else if (c inside {[8'h41:8'h5A]})
            idx = 6'(c - 8'h41);
        else if (c inside {[8'h30:8'h39]})
            idx = 6'(c - 8'h30) + 6'(LETTER_COUNT);
        else
            res.valid = 1'b0;
        res.code = CODE_ROM[idx];
        return res;
    endfunction

endpackage

/* hw/rtl/mck_front.sv */
// mck_front: accepts command transactions and classifies them into queue ops
// depends on mck_pkg (command and op types, code table)
module mck_front import mck_pkg::*;
(
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  mck_cmd_t cmd,
    output logic     push,
    output mck_op_t  push_op,
    input  logic     q_full
);

    mck_lookup_t lk;

    assign cmd_ready = !q_full;
    assign push      = cmd_valid && !q_full;

    always_comb
    begin
        lk           = code_lookup(cmd.char_code);
        push_op.code = lk.code;
        case (cmd.func)
            FUNC_PUT:   push_op.kind = lk.valid ? OP_PUT : OP_NOP;
            FUNC_TICK:  push_op.kind = OP_TICK;
            FUNC_CLEAR: push_op.kind = OP_CLEAR;
            default:    push_op.kind = OP_NOP;
        endcase
    end

endmodule

/* hw/rtl/mck_queue.sv */
// mck_queue: short op queue that decouples the front from the back
// depends on mck_pkg (op type, queue depth)
module mck_queue import mck_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  mck_op_t push_op,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output mck_op_t head_op
);

    mck_op_t              slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

endmodule

/* hw/rtl/mck_back.sv */
// mck_back: character store, element sequencer, timing registers and status register
// depends on mck_pkg (op and status types, store geometry, register indexes)
module mck_back import mck_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  mck_op_t     q_op,
    output logic        pop,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        status_valid,
    input  logic        status_ready,
    output mck_status_t status
);

    // timing registers
    logic [7:0] dit_reg, dah_reg, egap_reg, cgap_reg;

    // character store, no reset: reads are guarded by the fill count
    logic [7:0]         store_mem [FIFO_DEPTH];
    logic               store_we;
    logic [FIFO_AW-1:0] head_reg, head_next;
    logic [FIFO_AW-1:0] tail_reg, tail_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    // sender state
    logic [2:0] elems_reg, elems_next;
    logic [4:0] pat_reg, pat_next;
    logic [7:0] gap_reg, gap_next;
    logic [7:0] tone_reg, tone_next;
    logic       flag_reg, flag_next;

    logic        out_valid_reg, out_valid_next;
    mck_status_t out_reg, out_next;

    logic [8:0] gap_sum;
    logic [7:0] elem_len;
    logic [7:0] head_code;

    assign cfg_ready    = 1'b1;
    assign pop          = q_not_empty && (!out_valid_reg || status_ready);
    assign status_valid = out_valid_reg;
    assign status       = out_reg;
    assign gap_sum      = {1'b0, gap_reg} + {1'b0, egap_reg};
    assign elem_len     = pat_reg[0] ? dah_reg : dit_reg;
    assign head_code    = store_mem[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        elems_next = elems_reg;
        pat_next   = pat_reg;
        gap_next   = gap_reg;
        tone_next  = tone_reg;
        flag_next  = flag_reg;
        store_we   = 1'b0;
        out_next   = out_reg;

        if (pop)
        begin
            out_next.accepted = 1'b0;
            case (q_op.kind)
                OP_PUT:
                begin
                    if (count_reg != FIFO_CW'(FIFO_DEPTH))
                    begin
                        store_we          = 1'b1;
                        tail_next         = (tail_reg == FIFO_AW'(FIFO_DEPTH - 1)) ?
                                            '0 : tail_reg + 1'b1;
                        count_next        = count_reg + 1'b1;
                        out_next.accepted = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (tone_reg != '0)
                    begin
                        tone_next = tone_reg - 1'b1;
                        // tone ends: add element gap, saturating
                        if (tone_reg == 8'd1)
                        begin
                            flag_next = 1'b0;
                            gap_next  = gap_sum[8] ? 8'hFF : gap_sum[7:0];
                        end
                    end
                    else if (gap_reg != '0)
                        gap_next = gap_reg - 1'b1;
                    else if (elems_reg != '0)
                    begin
                        elems_next = elems_reg - 1'b1;
                        tone_next  = (elem_len == '0) ? 8'd1 : elem_len;
                        flag_next  = 1'b1;
                        pat_next   = {1'b0, pat_reg[4:1]};
                        // last element: extra silence up to the char gap
                        if (elems_reg == 3'd1)
                            gap_next = (cgap_reg > egap_reg) ? cgap_reg - egap_reg : '0;
                    end
                    else if (count_reg != '0)
                    begin
                        head_next  = (head_reg == FIFO_AW'(FIFO_DEPTH - 1)) ?
                                     '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        elems_next = head_code[7:5];
                        pat_next   = head_code[4:0];
                    end
                end
                OP_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                default: ;
            endcase
            out_next.tone_on = flag_next;
            out_next.idle    = (count_next == '0) && (elems_next == '0) &&
                               (tone_next == '0) && (gap_next == '0);
        end

        if (pop)
            out_valid_next = 1'b1;
        else if (status_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            elems_reg     <= '0;
            pat_reg       <= '0;
            gap_reg       <= '0;
            tone_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            dit_reg       <= DIT_RESET;
            dah_reg       <= DAH_RESET;
            egap_reg      <= ELEM_GAP_RESET;
            cgap_reg      <= CHAR_GAP_RESET;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            elems_reg     <= elems_next;
            pat_reg       <= pat_next;
            gap_reg       <= gap_next;
            tone_reg      <= tone_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DIT:      dit_reg  <= cfg_data;
                    CFG_DAH:      dah_reg  <= cfg_data;
                    CFG_ELEM_GAP: egap_reg <= cfg_data;
                    CFG_CHAR_GAP: cgap_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (store_we)
            store_mem[tail_reg] <= q_op.code;
    end

endmodule

/* hw/rtl/morse_code_keyer.sv */
// morse_code_keyer: top level of the morse keyer, front classifier, op queue and sender
// depends on mck_pkg, mck_front, mck_queue and mck_back
//
//  channel   dir  handshake                payload
//  cmd       in   cmd_valid / cmd_ready    mck_cmd_t    {func, char_code}
//  status    out  status_valid/ready       mck_status_t {tone_on, idle, accepted}
//  cfg       in   cfg_valid / cfg_ready    cfg_index[1:0], cfg_data[7:0]
//
// one command transaction per clock; each gives exactly one status transaction,
// registered first in the op queue and then in the status register, and the sender
// executes one op per clock
// the front stalls only when the two-entry op queue is full; the back stalls
// only while the status register holds a transaction that is not taken
// reset is asynchronous and active low, and the block is usable in the next cycle
// cfg is always ready and takes one register write per clock
module morse_code_keyer import mck_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  mck_cmd_t    cmd,
    output logic        status_valid,
    input  logic        status_ready,
    output mck_status_t status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // front to queue
    logic    push;
    mck_op_t push_op;
    logic    q_full;

    // queue to back
    logic    q_not_empty;
    logic    pop;
    mck_op_t q_op;

    // decode function and look up the code byte for a put
    mck_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .push      (push),
        .push_op   (push_op),
        .q_full    (q_full)
    );

    // decoupling queue of classified ops
    mck_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_op   (q_op)
    );

    // character store, tone and gap counters, timing registers, status output
    mck_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_op         (q_op),
        .pop          (pop),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status_valid (status_valid),
        .status_ready (status_ready),
        .status       (status)
    );

endmodule

/* tb/testbench.sv */
// testbench: self-checking regression for the morse keyer, directed rows then random phases
// depends on mck_pkg and morse_code_keyer; statuses are checked against an in-bench model
// of the character queue and the tone and gap counters
module testbench;
    import mck_pkg::*;

    localparam logic [1:0] FUNC_NOP     = 2'd3;
    localparam int         RANDOM_ITEMS = 1800;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         OPENING_ROWS = 30;

    // code byte per character: element count in [7:5], pattern in [4:0], lsb first, 1 is a dah
    localparam logic [7:0] MORSE_CODES [36] = '{
        {3'd2, 5'd2},  {3'd4, 5'd1},  {3'd4, 5'd5},  {3'd3, 5'd1},  {3'd1, 5'd0},
        {3'd4, 5'd4},  {3'd3, 5'd3},  {3'd4, 5'd0},  {3'd2, 5'd0},  {3'd4, 5'd14},
        {3'd3, 5'd5},  {3'd4, 5'd2},  {3'd2, 5'd3},  {3'd2, 5'd1},  {3'd3, 5'd7},
        {3'd4, 5'd6},  {3'd4, 5'd11}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
        {3'd3, 5'd4},  {3'd4, 5'd8},  {3'd3, 5'd6},  {3'd4, 5'd9},  {3'd4, 5'd13},
        {3'd4, 5'd3},
        {3'd5, 5'd31}, {3'd5, 5'd30}, {3'd5, 5'd28}, {3'd5, 5'd24}, {3'd5, 5'd16},
        {3'd5, 5'd0},  {3'd5, 5'd1},  {3'd5, 5'd3},  {3'd5, 5'd7},  {3'd5, 5'd15}
    };

    // one opening row: a register write or a command, with a typed status where obvious
    typedef struct packed {
        logic       is_write;
        logic [1:0] reg_idx;
        logic [7:0] reg_val;
        logic [1:0] func;
        logic [7:0] ch;
        logic       typed;
        logic [2:0] want;     // {tone_on, idle, accepted}
    } dir_step_t;

    localparam dir_step_t OPENING [OPENING_ROWS] = '{
        // fresh out of reset: nothing queued, nothing sounding
        '{1'b0, CFG_DIT,      8'd0,   FUNC_TICK,  8'h00, 1'b1, 3'b010},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_NOP,   8'h5A, 1'b1, 3'b010},
        // characters outside letters and digits, including the range edges
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h00, 1'b1, 3'b010},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'hFF, 1'b1, 3'b010},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h40, 1'b1, 3'b010},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h5B, 1'b1, 3'b010},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h60, 1'b1, 3'b010},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h7B, 1'b1, 3'b010},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h2F, 1'b1, 3'b010},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h3A, 1'b1, 3'b010},
        // zero tone lengths, no element gap, widest char gap
        '{1'b1, CFG_DIT,      8'd0,   FUNC_NOP,   8'h00, 1'b0, 3'b000},
        '{1'b1, CFG_DAH,      8'd0,   FUNC_NOP,   8'h00, 1'b0, 3'b000},
        '{1'b1, CFG_ELEM_GAP, 8'd0,   FUNC_NOP,   8'h00, 1'b0, 3'b000},
        '{1'b1, CFG_CHAR_GAP, 8'd255, FUNC_NOP,   8'h00, 1'b0, 3'b000},
        // 'e': load, start its only element, then widen the element gap so it saturates
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h65, 1'b1, 3'b001},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_TICK,  8'h00, 1'b0, 3'b000},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_TICK,  8'h00, 1'b0, 3'b000},
        '{1'b1, CFG_ELEM_GAP, 8'd255, FUNC_NOP,   8'h00, 1'b0, 3'b000},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_TICK,  8'h00, 1'b0, 3'b000},
        // first and last letter of each case and both digit ends
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h61, 1'b1, 3'b001},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h5A, 1'b1, 3'b001},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h30, 1'b1, 3'b001},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h39, 1'b1, 3'b001},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h7A, 1'b1, 3'b001},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_PUT,   8'h41, 1'b1, 3'b001},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_CLEAR, 8'h00, 1'b0, 3'b000},
        '{1'b0, CFG_DIT,      8'd0,   FUNC_TICK,  8'h00, 1'b0, 3'b000},
        // longest tones, char gap below element gap
        '{1'b1, CFG_DAH,      8'd255, FUNC_NOP,   8'h00, 1'b0, 3'b000},
        '{1'b1, CFG_DIT,      8'd255, FUNC_NOP,   8'h00, 1'b0, 3'b000},
        '{1'b1, CFG_CHAR_GAP, 8'd0,   FUNC_NOP,   8'h00, 1'b0, 3'b000}
    };

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cmd_valid    = 1'b0;
    logic        cmd_ready;
    mck_cmd_t    cmd          = '0;
    logic        status_valid;
    logic        status_ready = 1'b0;
    mck_status_t status;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = '0;
    logic [7:0]  cfg_data     = '0;

    // in-bench keyer state
    logic [7:0]  code_ring [FIFO_DEPTH];
    int          ring_rd, ring_wr, ring_fill;
    int          elems_left;
    logic [4:0]  dah_mask;
    int          silence_ticks, sound_ticks;
    logic        sounding;
    int          len_dit, len_dah, gap_elem, gap_char;

    // statuses still owed by the block, oldest first
    mck_status_t status_due [$];

    bit          calm = 1'b0;      // phase with no idling on either side
    int          mismatches = 0;
    int          n_cmds = 0, n_queued = 0, n_refused = 0, n_ticks = 0, n_clears = 0;
    int          n_writes = 0, n_tone_on = 0;
    int          quiet_cycles = 0;

    morse_code_keyer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .status_valid (status_valid),
        .status_ready (status_ready),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void keyer_reset();
        len_dit       = 4;
        len_dah       = 12;
        gap_elem      = 8;
        gap_char      = 28;
        ring_rd       = 0;
        ring_wr       = 0;
        ring_fill     = 0;
        elems_left    = 0;
        dah_mask      = '0;
        silence_ticks = 0;
        sound_ticks   = 0;
        sounding      = 1'b0;
    endfunction

    // {found, code byte}; letters of either case, then digits after the alphabet
    function automatic logic [8:0] morse_code_of(input logic [7:0] ch);
        if (ch >= 8'h61 && ch <= 8'h7A)
            return {1'b1, MORSE_CODES[ch - 8'h61]};
        if (ch >= 8'h41 && ch <= 8'h5A)
            return {1'b1, MORSE_CODES[ch - 8'h41]};
        if (ch >= 8'h30 && ch <= 8'h39)
            return {1'b1, MORSE_CODES[26 + (ch - 8'h30)]};
        return '0;
    endfunction

    // advance the in-bench keyer by one command and give the status it reports
    function automatic mck_status_t keyer_next_status(input mck_cmd_t c);
        mck_status_t st;
        logic [8:0]  hit;
        logic [7:0]  b;
        int          sum;
        int          len;
        st = '0;
        case (c.func)
            FUNC_PUT:
            begin
                hit = morse_code_of(c.char_code);
                if (hit[8] && ring_fill < FIFO_DEPTH)
                begin
                    code_ring[ring_wr] = hit[7:0];
                    ring_wr            = (ring_wr + 1) % FIFO_DEPTH;
                    ring_fill++;
                    st.accepted        = 1'b1;
                end
            end
            FUNC_TICK:
            begin
                if (sound_ticks != 0)
                begin
                    sound_ticks--;
                    // element over: element gap piles on top of any char gap, capped
                    if (sound_ticks == 0)
                    begin
                        sounding      = 1'b0;
                        sum           = silence_ticks + gap_elem;
                        silence_ticks = (sum > 255) ? 255 : sum;
                    end
                end
                else if (silence_ticks != 0)
                    silence_ticks--;
                else if (elems_left != 0)
                begin
                    elems_left--;
                    len         = dah_mask[0] ? len_dah : len_dit;
                    sound_ticks = (len == 0) ? 1 : len;
                    sounding    = 1'b1;
                    dah_mask    = dah_mask >> 1;
                    if (elems_left == 0)
                        silence_ticks = (gap_char > gap_elem) ? gap_char - gap_elem : 0;
                end
                else if (ring_fill != 0)
                begin
                    // loading a character takes the whole tick
                    b          = code_ring[ring_rd];
                    ring_rd    = (ring_rd + 1) % FIFO_DEPTH;
                    ring_fill--;
                    elems_left = b[7:5];
                    dah_mask   = b[4:0];
                end
            end
            FUNC_CLEAR:
            begin
                ring_rd   = 0;
                ring_wr   = 0;
                ring_fill = 0;
            end
            default: ;
        endcase
        st.tone_on = sounding;
        st.idle    = (ring_fill == 0 && elems_left == 0 && sound_ticks == 0 &&
                      silence_ticks == 0);
        return st;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 35);
        if (r < 26)
            return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(r);
        return 8'h30 + 8'(r - 26);
    endfunction

    // present one command transaction, then log what it should produce
    task automatic send_cmd(input mck_cmd_t c, input logic typed, input mck_status_t want);
        int          gap;
        mck_status_t predicted;
        gap = calm ? 0 : $urandom_range(0, 4);
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        predicted = keyer_next_status(c);
        status_due.push_back(typed ? want : predicted);
        n_cmds++;
        if (c.func == FUNC_PUT)
        begin
            if (predicted.accepted)
                n_queued++;
            else
                n_refused++;
        end
        if (c.func == FUNC_TICK)
            n_ticks++;
        if (c.func == FUNC_CLEAR)
            n_clears++;
    endtask

    // registers change only once every owed status is back
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cmd_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DIT:      len_dit  = val;
            CFG_DAH:      len_dah  = val;
            CFG_ELEM_GAP: gap_elem = val;
            CFG_CHAR_GAP: gap_char = val;
            default: ;
        endcase
        n_writes++;
    endtask

    // status side: random back-pressure, every transaction checked against the oldest due
    initial
    begin
        mck_status_t want;
        int          w;
        wait (rst_n === 1'b1);
        forever
        begin
            w = calm ? 0 : $urandom_range(0, 4);
            if (w > 0)
            begin
                status_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            status_ready <= 1'b1;
            do
                @(posedge clk);
            while (!status_valid);
            if (status.tone_on === 1'b1)
                n_tone_on++;
            if (status_due.size() == 0)
            begin
                $error("status transaction with nothing outstanding: %p", status);
                mismatches++;
            end
            else
            begin
                want = status_due.pop_front();
                if (status.tone_on !== want.tone_on)
                begin
                    $error("tone_on: expected %0b, got %0b", want.tone_on, status.tone_on);
                    mismatches++;
                end
                if (status.idle !== want.idle)
                begin
                    $error("idle: expected %0b, got %0b", want.idle, status.idle);
                    mismatches++;
                end
                if (status.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0b, got %0b", want.accepted, status.accepted);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (status_valid && status_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("morse_code_keyer regression: fail");
            $finish;
        end
    end

    initial
    begin
        dir_step_t  row;
        mck_cmd_t   c;
        int         burst, span, r, random_sent;
        logic [7:0] v;
        random_sent = 0;
        keyer_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        for (int i = 0; i < OPENING_ROWS; i++)
        begin
            row = OPENING[i];
            if (row.is_write)
                write_reg(row.reg_idx, row.reg_val);
            else
            begin
                c.func      = row.func;
                c.char_code = row.ch;
                send_cmd(c, row.typed, mck_status_t'(row.want));
            end
        end

        // random phases: new settings, a burst of characters, then mostly ticks
        while (random_sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            for (int idx = 0; idx < 4; idx++)
            begin
                if ($urandom_range(0, 1))
                begin
                    // mostly short timings so characters finish; rarely the extremes
                    r = $urandom_range(0, 15);
                    if (r == 0)
                        v = 8'd0;
                    else if (r == 1)
                        v = 8'd255;
                    else
                    begin
                        case (2'(idx))
                            CFG_DIT:      v = 8'($urandom_range(0, 3));
                            CFG_DAH:      v = 8'($urandom_range(1, 6));
                            CFG_ELEM_GAP: v = 8'($urandom_range(0, 4));
                            default:      v = 8'($urandom_range(0, 12));
                        endcase
                    end
                    write_reg(2'(idx), v);
                end
            end
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++)
            begin
                c.func      = FUNC_PUT;
                c.char_code = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                          : pick_char();
                send_cmd(c, 1'b0, '0);
                random_sent++;
            end
            span = $urandom_range(30, 70);
            for (int k = 0; k < span; k++)
            begin
                r           = $urandom_range(0, 99);
                c.char_code = 8'($urandom_range(0, 255));
                if (r < 70)
                    c.func = FUNC_TICK;
                else if (r < 80)
                begin
                    c.func      = FUNC_PUT;
                    c.char_code = pick_char();
                end
                else if (r < 88)
                    c.func = FUNC_PUT;
                else if (r < 93)
                    c.func = FUNC_CLEAR;
                else if (r < 96)
                    c.func = FUNC_NOP;
                else
                    c.func = 2'($urandom_range(0, 3));
                send_cmd(c, 1'b0, '0);
                random_sent++;
            end
        end

        // drain, then keep the clock running to catch any stray status
        calm = 1'b0;
        cmd_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("exercised %0d commands: %0d characters queued, %0d refused, %0d ticks, %0d clears",
                 n_cmds, n_queued, n_refused, n_ticks, n_clears);
        $display("%0d register writes, %0d statuses with the tone sounding", n_writes, n_tone_on);
        if (mismatches == 0)
            $display("morse_code_keyer regression: pass");
        else
            $display("morse_code_keyer regression: fail");
        $finish;
    end

endmodule
